>>> hw/rtl/sav_pkg.sv
// ----------------------------------------------------------------------------
// sav_pkg
// Shared types, codes and sizes for the snapshot versioned array.
// ----------------------------------------------------------------------------
package sav_pkg;

    localparam int ELEMENTS   = 1024;
    localparam int MAX_SNAPS  = 256;
    localparam int HIST_DEPTH = 8;
    localparam int VALUE_BITS = 30;

    localparam int IDX_W   = $clog2(ELEMENTS);
    localparam int LEN_W   = 11;
    localparam int SNAP_W  = 8;
    localparam int SCNT_W  = $clog2(MAX_SNAPS + 1);
    localparam int CNT_W   = $clog2(HIST_DEPTH + 1);
    localparam int SLOT_W  = (HIST_DEPTH > 1) ? $clog2(HIST_DEPTH) : 1;
    localparam int HADDR_W = IDX_W + SLOT_W;

    localparam logic [1:0] ACT_SET  = 2'd0;
    localparam logic [1:0] ACT_SNAP = 2'd1;
    localparam logic [1:0] ACT_GET  = 2'd2;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_BAD_INDEX = 3'd1;
    localparam logic [2:0] ST_NOT_TAKEN = 3'd2;
    localparam logic [2:0] ST_HIST_FULL = 3'd3;
    localparam logic [2:0] ST_EXHAUSTED = 3'd4;

    typedef struct packed {
        logic [1:0]            action;
        logic [9:0]            item_index;
        logic [29:0]           write_value;
        logic [7:0]            snap_query;
    } request_t;

    typedef struct packed {
        logic [29:0]           read_value;
        logic [7:0]            snap_number;
        logic [2:0]            status;
    } result_t;

    typedef struct packed {
        logic                  dirty;
        logic [CNT_W-1:0]      count;
        logic [VALUE_BITS-1:0] value;
    } elem_word_t;

    typedef struct packed {
        logic [SNAP_W-1:0]     snap_id;
        logic [VALUE_BITS-1:0] value;
    } hist_word_t;

    typedef enum logic [2:0] {
        RES_ZERO,
        RES_BAD_INDEX,
        RES_NOT_TAKEN,
        RES_HIST_FULL,
        RES_EXHAUSTED,
        RES_SNAP,
        RES_VALUE
    } res_kind_t;

    typedef struct packed {
        logic      latch;
        logic      sel_scan;
        logic      scan_clr;
        logic      scan_inc;
        logic      clr_wr;
        logic      set_wr;
        logic      cmt_wr;
        logic      ptr_load;
        logic      ptr_dec;
        logic      snap_inc;
        logic      res_valid;
        res_kind_t res_kind;
    } cmd_t;

    typedef struct packed {
        logic [1:0] action;
        logic       idx_ok;
        logic       query_ok;
        logic       exhausted;
        logic       scan_last;
        logic       elem_dirty;
        logic       elem_full;
        logic       ptr_zero;
        logic       hist_hit;
    } stat_t;

endpackage

>>> hw/rtl/sav_ram.sv
// ----------------------------------------------------------------------------
// sav_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module sav_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> hw/rtl/sav_dpath.sv
// ----------------------------------------------------------------------------
// sav_dpath
// Element and history stores, scan and history pointers, snapshot counter,
// length register and result register.
// ----------------------------------------------------------------------------
module sav_dpath
    import sav_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  request_t         request,
    input  logic             cfg_we,
    input  logic [LEN_W-1:0] cfg_data,
    input  cmd_t             cmd,
    output stat_t            stat,
    output logic             done,
    output result_t          result
);

    request_t          req_reg;
    logic [IDX_W-1:0]  scan_reg;
    logic [CNT_W-1:0]  ptr_reg;
    logic [SCNT_W-1:0] snap_cnt_reg;
    logic [LEN_W-1:0]  len_reg;
    logic              done_reg;
    result_t           res_reg;
    result_t           res_next;

    elem_word_t        elem_rd;
    elem_word_t        elem_wd;
    logic [IDX_W-1:0]  elem_addr;
    logic              elem_we;
    hist_word_t        hist_rd;
    hist_word_t        hist_wd;
    logic [HADDR_W-1:0] hist_waddr;
    logic [HADDR_W-1:0] hist_raddr;
    logic [CNT_W-1:0]  ptr_m1;
    logic [LEN_W-1:0]  len_eff;

    assign elem_addr = cmd.sel_scan ? scan_reg : req_reg.item_index;
    assign elem_we   = cmd.clr_wr | cmd.set_wr | cmd.cmt_wr;

    always_comb
    begin
        elem_wd = '0;
        if (cmd.set_wr)
        begin
            elem_wd.dirty = 1'b1;
            elem_wd.count = elem_rd.count;
            elem_wd.value = req_reg.write_value;
        end
        else if (cmd.cmt_wr)
        begin
            elem_wd.dirty = 1'b0;
            elem_wd.count = elem_rd.count + CNT_W'(1);
            elem_wd.value = elem_rd.value;
        end
    end

    sav_ram #(
        .WIDTH ($bits(elem_word_t)),
        .DEPTH (ELEMENTS)
    ) u_elem_ram (
        .clk   (clk),
        .we    (elem_we),
        .waddr (elem_addr),
        .wdata (elem_wd),
        .raddr (elem_addr),
        .rdata (elem_rd)
    );

    assign ptr_m1     = ptr_reg - CNT_W'(1);
    assign hist_waddr = {scan_reg, elem_rd.count[SLOT_W-1:0]};
    assign hist_raddr = {req_reg.item_index, ptr_m1[SLOT_W-1:0]};
    assign hist_wd    = '{snap_id: snap_cnt_reg[SNAP_W-1:0], value: elem_rd.value};

    sav_ram #(
        .WIDTH ($bits(hist_word_t)),
        .DEPTH (ELEMENTS * HIST_DEPTH)
    ) u_hist_ram (
        .clk   (clk),
        .we    (cmd.cmt_wr),
        .waddr (hist_waddr),
        .wdata (hist_wd),
        .raddr (hist_raddr),
        .rdata (hist_rd)
    );

    // lengths above the element count act as the element count
    assign len_eff = (len_reg > LEN_W'(ELEMENTS)) ? LEN_W'(ELEMENTS) : len_reg;

    assign stat.action     = req_reg.action;
    assign stat.idx_ok     = LEN_W'(req_reg.item_index) < len_eff;
    assign stat.query_ok   = SCNT_W'(req_reg.snap_query) < snap_cnt_reg;
    assign stat.exhausted  = snap_cnt_reg >= SCNT_W'(MAX_SNAPS);
    assign stat.scan_last  = scan_reg == IDX_W'(ELEMENTS - 1);
    assign stat.elem_dirty = elem_rd.dirty;
    assign stat.elem_full  = elem_rd.count >= CNT_W'(HIST_DEPTH);
    assign stat.ptr_zero   = ptr_reg == '0;
    assign stat.hist_hit   = hist_rd.snap_id <= req_reg.snap_query;

    always_comb
    begin
        res_next = '0;
        case (cmd.res_kind)
            RES_ZERO:      res_next.status = ST_OK;
            RES_BAD_INDEX: res_next.status = ST_BAD_INDEX;
            RES_NOT_TAKEN: res_next.status = ST_NOT_TAKEN;
            RES_HIST_FULL: res_next.status = ST_HIST_FULL;
            RES_EXHAUSTED: res_next.status = ST_EXHAUSTED;
            RES_SNAP:      res_next.snap_number = snap_cnt_reg[SNAP_W-1:0];
            RES_VALUE:     res_next.read_value = hist_rd.value;
            default:       res_next = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_reg     <= '0;
            snap_cnt_reg <= '0;
            len_reg      <= LEN_W'(1024);
            done_reg     <= 1'b0;
        end
        else
        begin
            if (cmd.scan_clr)
            begin
                scan_reg <= '0;
            end
            else if (cmd.scan_inc)
            begin
                scan_reg <= scan_reg + IDX_W'(1);
            end
            if (cmd.snap_inc)
            begin
                snap_cnt_reg <= snap_cnt_reg + SCNT_W'(1);
            end
            if (cfg_we)
            begin
                len_reg <= cfg_data;
            end
            done_reg <= cmd.res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            req_reg <= request;
        end
        if (cmd.ptr_load)
        begin
            ptr_reg <= elem_rd.count;
        end
        else if (cmd.ptr_dec)
        begin
            ptr_reg <= ptr_m1;
        end
        if (cmd.res_valid)
        begin
            res_reg <= res_next;
        end
    end

    assign done   = done_reg;
    assign result = res_reg;

endmodule

>>> hw/rtl/sav_ctrl.sv
// ----------------------------------------------------------------------------
// sav_ctrl
// Sequencer: clearing pass, set read-modify-write, two-pass snap scan and
// newest-first history search for get.
// ----------------------------------------------------------------------------
module sav_ctrl
    import sav_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  start,
    input  stat_t stat,
    output logic  busy,
    output cmd_t  cmd
);

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_DECODE,
        S_SET_WR,
        S_GET_CNT,
        S_GET_RD,
        S_GET_CHK,
        S_CHK_RD,
        S_CHK_EVAL,
        S_CMT_RD,
        S_CMT_EVAL
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   busy_reg;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.res_kind = RES_ZERO;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.sel_scan = 1'b1;
                cmd.clr_wr   = 1'b1;
                cmd.scan_inc = 1'b1;
                if (stat.scan_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.latch  = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                case (stat.action)
                    ACT_SET:
                    begin
                        if (!stat.idx_ok)
                        begin
                            cmd.res_valid = 1'b1;
                            cmd.res_kind  = RES_BAD_INDEX;
                            state_next    = S_IDLE;
                        end
                        else
                        begin
                            state_next = S_SET_WR;
                        end
                    end
                    ACT_SNAP:
                    begin
                        if (stat.exhausted)
                        begin
                            cmd.res_valid = 1'b1;
                            cmd.res_kind  = RES_EXHAUSTED;
                            state_next    = S_IDLE;
                        end
                        else
                        begin
                            cmd.scan_clr = 1'b1;
                            state_next   = S_CHK_RD;
                        end
                    end
                    ACT_GET:
                    begin
                        if (!stat.idx_ok)
                        begin
                            cmd.res_valid = 1'b1;
                            cmd.res_kind  = RES_BAD_INDEX;
                            state_next    = S_IDLE;
                        end
                        else if (!stat.query_ok)
                        begin
                            cmd.res_valid = 1'b1;
                            cmd.res_kind  = RES_NOT_TAKEN;
                            state_next    = S_IDLE;
                        end
                        else
                        begin
                            state_next = S_GET_CNT;
                        end
                    end
                    default:
                    begin
                        cmd.res_valid = 1'b1;
                        cmd.res_kind  = RES_ZERO;
                        state_next    = S_IDLE;
                    end
                endcase
            end
            S_SET_WR:
            begin
                cmd.set_wr    = 1'b1;
                cmd.res_valid = 1'b1;
                state_next    = S_IDLE;
            end
            S_GET_CNT:
            begin
                cmd.ptr_load = 1'b1;
                state_next   = S_GET_RD;
            end
            S_GET_RD:
            begin
                if (stat.ptr_zero)
                begin
                    cmd.res_valid = 1'b1;
                    state_next    = S_IDLE;
                end
                else
                begin
                    state_next = S_GET_CHK;
                end
            end
            S_GET_CHK:
            begin
                if (stat.hist_hit)
                begin
                    cmd.res_valid = 1'b1;
                    cmd.res_kind  = RES_VALUE;
                    state_next    = S_IDLE;
                end
                else
                begin
                    cmd.ptr_dec = 1'b1;
                    state_next  = S_GET_RD;
                end
            end
            S_CHK_RD:
            begin
                cmd.sel_scan = 1'b1;
                state_next   = S_CHK_EVAL;
            end
            S_CHK_EVAL:
            begin
                cmd.sel_scan = 1'b1;
                if (stat.elem_dirty && stat.elem_full)
                begin
                    cmd.res_valid = 1'b1;
                    cmd.res_kind  = RES_HIST_FULL;
                    state_next    = S_IDLE;
                end
                else if (stat.scan_last)
                begin
                    cmd.scan_clr = 1'b1;
                    state_next   = S_CMT_RD;
                end
                else
                begin
                    cmd.scan_inc = 1'b1;
                    state_next   = S_CHK_RD;
                end
            end
            S_CMT_RD:
            begin
                cmd.sel_scan = 1'b1;
                state_next   = S_CMT_EVAL;
            end
            S_CMT_EVAL:
            begin
                cmd.sel_scan = 1'b1;
                cmd.cmt_wr   = stat.elem_dirty;
                if (stat.scan_last)
                begin
                    cmd.res_valid = 1'b1;
                    cmd.res_kind  = RES_SNAP;
                    cmd.snap_inc  = 1'b1;
                    state_next    = S_IDLE;
                end
                else
                begin
                    cmd.scan_inc = 1'b1;
                    state_next   = S_CMT_RD;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            busy_reg  <= 1'b1;
        end
        else
        begin
            state_reg <= state_next;
            busy_reg  <= state_next != S_IDLE;
        end
    end

    assign busy = busy_reg;

endmodule

>>> hw/rtl/snapshot_versioned_array_top.sv
// ----------------------------------------------------------------------------
// snapshot_versioned_array_top
// Versioned array with set, snap and get actions over per-element histories.
//
//   channel   handshake            payload
//   -------   ------------------   ----------------------
//   request   start & !busy         request (request_t)
//   result    done, one cycle      result  (result_t)
//   config    cfg_we               cfg_data (array_length)
//
// After reset a clearing pass over all 1024 elements zeroes the element
// store; busy stays high throughout. Set reads then writes its element,
// get searches the history newest first, and snap makes up to two passes
// over all 1024 elements on the element RAM port. One item at a time;
// done pulses for one cycle as busy falls. The receiver cannot stall.
// ----------------------------------------------------------------------------
module snapshot_versioned_array_top
    import sav_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  request_t         request,
    input  logic             cfg_we,
    input  logic [LEN_W-1:0] cfg_data,
    output logic             done,
    output result_t          result
);

    cmd_t  cmd;
    stat_t stat;

    sav_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .busy  (busy),
        .cmd   (cmd)
    );

    sav_dpath u_dpath (
        .clk      (clk),
        .rst_n    (rst_n),
        .request  (request),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .cmd      (cmd),
        .stat     (stat),
        .done     (done),
        .result   (result)
    );

endmodule
